/* hdl/stwm_pkg.sv */
`default_nettype none

package stwm_pkg;

  // Table size and window geometry
  localparam int TABLE_DEPTH = 64;
  localparam int WIN_DIM     = 3;
  localparam int NCELL       = WIN_DIM * WIN_DIM;
  localparam int CENTRE      = NCELL / 2;
  localparam int CELL_W      = 3;
  localparam int CELLS_W     = NCELL * CELL_W;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int NXFORM      = 32;
  localparam int XF_W        = 5;

  // Cell codes
  localparam logic [CELL_W-1:0] C_BLACK    = 3'd1;
  localparam logic [CELL_W-1:0] C_WHITE    = 3'd2;
  localparam logic [CELL_W-1:0] C_NOTWHITE = 3'd4;
  localparam logic [CELL_W-1:0] C_NOTBLACK = 3'd5;
  localparam logic [CELL_W-1:0] C_ANY      = 3'd6;

  // Commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_MATCH = 1'b1;

  typedef struct packed {
    logic               command;
    logic [CELLS_W-1:0] cells;
    logic [1:0]         stone_color;
    logic [7:0]         load_class;
    logic [7:0]         load_subclass;
  } in_word_t;

  typedef struct packed {
    logic       matched;
    logic [7:0] found_class;
    logic [7:0] found_subclass;
    logic [5:0] entry_index;
    logic       colors_swapped;
    logic [1:0] quarter_turns;
    logic       rows_flipped;
    logic       cols_flipped;
    logic       load_refused;
  } out_word_t;

  typedef struct packed {
    logic [7:0]         pclass;
    logic [7:0]         psub;
    logic [CELLS_W-1:0] cells;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } tbl_req_t;

  typedef struct packed {
    logic            hit;
    logic [XF_W-1:0] xform;
  } cmp_res_t;

  // Window cell against pattern cell, wildcards on either side
  function automatic logic cell_ok(input logic [CELL_W-1:0] w, input logic [CELL_W-1:0] p);
    logic ok;
    if (w == p)                         ok = 1'b1;
    else if (w == C_ANY || p == C_ANY)  ok = 1'b1;
    else if (p == C_NOTWHITE)           ok = (w != C_WHITE);
    else if (p == C_NOTBLACK)           ok = (w != C_BLACK);
    else if (w == C_NOTWHITE)           ok = (p != C_WHITE);
    else if (w == C_NOTBLACK)           ok = (p != C_BLACK);
    else                                ok = 1'b0;
    return ok;
  endfunction

  // Exchange black/white and notwhite/notblack
  function automatic logic [CELL_W-1:0] swap_code(input logic [CELL_W-1:0] w);
    logic [CELL_W-1:0] s;
    case (w)
      C_WHITE:    s = C_BLACK;
      C_BLACK:    s = C_WHITE;
      C_NOTWHITE: s = C_NOTBLACK;
      C_NOTBLACK: s = C_NOTWHITE;
      default:    s = w;
    endcase
    return s;
  endfunction

  // Source cell of transformed position i: turns, then row flip, then column flip
  function automatic int src_cell(input int tn, input int fr, input int fc, input int i);
    int r;
    int c;
    int t;
    r = i / WIN_DIM;
    c = i % WIN_DIM;
    if (fc != 0) c = WIN_DIM - 1 - c;
    if (fr != 0) r = WIN_DIM - 1 - r;
    for (int k = 0; k < 3; k++) begin
      if (k < tn) begin
        t = r;
        r = WIN_DIM - 1 - c;
        c = t;
      end
    end
    return r * WIN_DIM + c;
  endfunction

endpackage

`default_nettype wire

/* hdl/stwm_table.sv */
`default_nettype none

module stwm_table (
  input  wire logic              clk,
  input  wire stwm_pkg::tbl_req_t req,
  input  wire stwm_pkg::entry_t   wr_data,
  output stwm_pkg::entry_t        rd_data
);

  stwm_pkg::entry_t mem [stwm_pkg::TABLE_DEPTH];
  stwm_pkg::entry_t rd_data_r;

  // Write on load, registered read during scan
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hdl/stwm_xform_cmp.sv */
`default_nettype none

module stwm_xform_cmp (
  input  wire logic [stwm_pkg::CELLS_W-1:0] win,
  input  wire logic [stwm_pkg::CELLS_W-1:0] pat,
  output stwm_pkg::cmp_res_t                res
);

  logic [stwm_pkg::NXFORM-1:0] hit;

  // Test every transform of the window against one entry
  for (genvar t = 0; t < stwm_pkg::NXFORM; t++) begin : g_xf
    localparam int SW = t / 16;
    localparam int TN = (t / 4) % 4;
    localparam int FR = (t / 2) % 2;
    localparam int FC = t % 2;
    logic [stwm_pkg::NCELL-1:0] ok;
    for (genvar i = 0; i < stwm_pkg::NCELL; i++) begin : g_cell
      localparam int S = stwm_pkg::src_cell(TN, FR, FC, i);
      logic [stwm_pkg::CELL_W-1:0] raw;
      logic [stwm_pkg::CELL_W-1:0] cw;
      assign raw   = win[S*stwm_pkg::CELL_W +: stwm_pkg::CELL_W];
      assign cw    = (SW != 0) ? stwm_pkg::swap_code(raw) : raw;
      assign ok[i] = stwm_pkg::cell_ok(cw, pat[i*stwm_pkg::CELL_W +: stwm_pkg::CELL_W]);
    end
    assign hit[t] = &ok;
  end

  // Pick the first transform in search order
  always_comb begin
    res.hit   = |hit;
    res.xform = '0;
    for (int t = stwm_pkg::NXFORM - 1; t >= 0; t--) begin
      if (hit[t]) res.xform = stwm_pkg::XF_W'(t);
    end
  end

endmodule

`default_nettype wire

/* hdl/symmetric_ternary_window_matcher.sv */
`default_nettype none

// Symmetry-invariant 3x3 wildcard pattern matcher.
// Input channel in_valid/in_ready/in_data carries one word per item: a load
// word appends an entry (nine cell codes, class, subclass) to the pattern
// table, a match word brings a window whose centre takes the stone colour.
// Every word yields exactly one result word on out_valid/out_ready/out_data.
// Load: the result is registered on acceptance and is valid in the next
// cycle; a load into a full table is dropped and flagged with load_refused.
// Match: entries are read from the single table read port one per cycle and
// each is tested combinationally against all 32 colour/turn/flip variants of
// the window; a match on an empty table is answered on acceptance without a
// scan. The scan stops at the first hit.
// The block takes one word at a time: loads may follow every cycle, a match
// holds the input for its whole scan; in_ready is low while a match scans
// and while a finished result cannot yet enter the output register.
// Reset clears the entry count and the handshake state; table contents are
// not cleared and are never read beyond the entry count.
// A stalled receiver holds the result in the output register; the next word
// may be accepted once that register is free or is being emptied.

module symmetric_ternary_window_matcher (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire stwm_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output stwm_pkg::out_word_t      out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUSH
  } state_t;

  state_t                          state_r, state_nxt;
  logic [stwm_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [stwm_pkg::CNT_W-1:0]      rd_addr_r, rd_addr_nxt;
  logic                            cmp_vld_r, cmp_vld_nxt;
  logic [stwm_pkg::IDX_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [stwm_pkg::CELLS_W-1:0]    win_r, win_nxt;
  logic                            out_valid_r, out_valid_nxt;
  stwm_pkg::out_word_t             out_r, out_nxt;
  stwm_pkg::out_word_t             res_r, res_nxt;

  stwm_pkg::tbl_req_t              req;
  stwm_pkg::entry_t                wr_entry;
  stwm_pkg::entry_t                rd_entry;
  stwm_pkg::cmp_res_t              cmp;

  logic                            accept;
  logic                            out_free;
  logic                            last_entry;
  logic [stwm_pkg::CELLS_W-1:0]    in_win;

  stwm_table u_table (
    .clk     (clk),
    .req     (req),
    .wr_data (wr_entry),
    .rd_data (rd_entry)
  );

  stwm_xform_cmp u_cmp (
    .win (win_r),
    .pat (rd_entry.cells),
    .res (cmp)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // Put the stone colour in the window centre
  always_comb begin
    in_win = in_data.cells;
    in_win[stwm_pkg::CENTRE*stwm_pkg::CELL_W +: stwm_pkg::CELL_W] =
      {1'b0, in_data.stone_color};
  end

  assign wr_entry.pclass = in_data.load_class;
  assign wr_entry.psub   = in_data.load_subclass;
  assign wr_entry.cells  = in_data.cells;

  assign last_entry = (stwm_pkg::CNT_W'(cmp_idx_r) + stwm_pkg::CNT_W'(1)) == cnt_r;

  // Sequencer: load, scan the table, hand the result over
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_addr_nxt   = rd_addr_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    win_nxt       = win_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    res_nxt       = res_r;
    req.wr_en     = 1'b0;
    req.wr_addr   = cnt_r[stwm_pkg::IDX_W-1:0];
    req.rd_en     = 1'b0;
    req.rd_addr   = rd_addr_r[stwm_pkg::IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.command == stwm_pkg::CMD_LOAD) begin
            out_nxt       = '0;
            out_valid_nxt = 1'b1;
            if (cnt_r >= stwm_pkg::CNT_W'(stwm_pkg::TABLE_DEPTH)) begin
              out_nxt.load_refused = 1'b1;
            end else begin
              req.wr_en = 1'b1;
              cnt_nxt   = cnt_r + stwm_pkg::CNT_W'(1);
            end
          end else if (cnt_r == '0) begin
            out_nxt       = '0;
            out_valid_nxt = 1'b1;
          end else begin
            win_nxt     = in_win;
            rd_addr_nxt = '0;
            state_nxt   = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read while comparing the previous entry
        if (rd_addr_r < cnt_r) begin
          req.rd_en   = 1'b1;
          rd_addr_nxt = rd_addr_r + stwm_pkg::CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_addr_r[stwm_pkg::IDX_W-1:0];
        end
        if (cmp_vld_r && (cmp.hit || last_entry)) begin
          res_nxt = '0;
          if (cmp.hit) begin
            res_nxt.matched        = 1'b1;
            res_nxt.found_class    = rd_entry.pclass;
            res_nxt.found_subclass = rd_entry.psub;
            res_nxt.entry_index    = 6'({6'd0, cmp_idx_r});
            res_nxt.colors_swapped = cmp.xform[4];
            res_nxt.quarter_turns  = cmp.xform[3:2];
            res_nxt.rows_flipped   = cmp.xform[1];
            res_nxt.cols_flipped   = cmp.xform[0];
          end
          req.rd_en   = 1'b0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = ST_PUSH;
        end
      end

      ST_PUSH: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_addr_r <= rd_addr_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    win_r     <= win_nxt;
    out_r     <= out_nxt;
    res_r     <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* verif/symmetric_ternary_window_matcher_test.sv */
module symmetric_ternary_window_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stwm_pkg::*;

  localparam int RANDOM_WORDS = 1030;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LONG_HOLD    = 500;
  localparam int HOLD_AFTER   = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int PRINT_CAP    = 200;

  localparam out_word_t NO_HIT = '0;

  typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_MOSTLY} rx_mode_t;

  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  // Our own copy of the pattern store
  logic [CELLS_W-1:0] pat_cells [TABLE_DEPTH];
  logic [7:0]         pat_class [TABLE_DEPTH];
  logic [7:0]         pat_sub   [TABLE_DEPTH];
  int                 pat_count = 0;

  out_word_t pending_results [$];
  int        errors      = 0;
  int        words_sent  = 0;
  int        cycle_count = 0;
  bit        hold_done   = 1'b0;

  always #6 clk = ~clk;

  symmetric_ternary_window_matcher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Pack nine cell codes, top left first
  function automatic logic [CELLS_W-1:0] grid(
    logic [2:0] c0, logic [2:0] c1, logic [2:0] c2,
    logic [2:0] c3, logic [2:0] c4, logic [2:0] c5,
    logic [2:0] c6, logic [2:0] c7, logic [2:0] c8);
    return {c8, c7, c6, c5, c4, c3, c2, c1, c0};
  endfunction

  function automatic stim_row_t row(logic cmd, logic [CELLS_W-1:0] cells, logic [1:0] stone,
                                    logic [7:0] cls, logic [7:0] sub, logic typed,
                                    out_word_t want);
    stim_row_t r;
    r.word.command       = cmd;
    r.word.cells         = cells;
    r.word.stone_color   = stone;
    r.word.load_class    = cls;
    r.word.load_subclass = sub;
    r.typed              = typed;
    r.want               = want;
    return r;
  endfunction

  // Recode a window: colour swap, then clockwise quarter turns, then row flip, then column flip
  function automatic logic [CELLS_W-1:0] orient(logic [CELLS_W-1:0] w, bit sw, int tn,
                                                bit fr, bit fc);
    logic [CELLS_W-1:0] t;
    logic [CELL_W-1:0]  code;
    if (sw) begin
      for (int i = 0; i < NCELL; i++) begin
        code = w[CELL_W*i +: CELL_W];
        if (code == C_BLACK) code = C_WHITE;
        else if (code == C_WHITE) code = C_BLACK;
        else if (code == C_NOTWHITE) code = C_NOTBLACK;
        else if (code == C_NOTBLACK) code = C_NOTWHITE;
        w[CELL_W*i +: CELL_W] = code;
      end
    end
    for (int n = 0; n < tn; n++) begin
      for (int r = 0; r < WIN_DIM; r++)
        for (int c = 0; c < WIN_DIM; c++)
          t[CELL_W*(r*WIN_DIM + WIN_DIM-1-c) +: CELL_W] = w[CELL_W*(c*WIN_DIM + r) +: CELL_W];
      w = t;
    end
    if (fr) begin
      for (int r = 0; r < WIN_DIM; r++)
        for (int c = 0; c < WIN_DIM; c++)
          t[CELL_W*(r*WIN_DIM + c) +: CELL_W] = w[CELL_W*((WIN_DIM-1-r)*WIN_DIM + c) +: CELL_W];
      w = t;
    end
    if (fc) begin
      for (int r = 0; r < WIN_DIM; r++)
        for (int c = 0; c < WIN_DIM; c++)
          t[CELL_W*(r*WIN_DIM + c) +: CELL_W] = w[CELL_W*(r*WIN_DIM + WIN_DIM-1-c) +: CELL_W];
      w = t;
    end
    return w;
  endfunction

  // Advance the pattern store by one word and return the result it must give
  function automatic out_word_t apply_word(in_word_t w);
    out_word_t          res;
    logic [CELLS_W-1:0] win;
    logic [CELLS_W-1:0] views [NXFORM];
    logic [CELL_W-1:0]  wc;
    logic [CELL_W-1:0]  pc;
    logic [4:0]         xf;
    bit                 ok;
    res = NO_HIT;
    if (w.command == CMD_LOAD) begin
      if (pat_count >= TABLE_DEPTH) begin
        res.load_refused = 1'b1;
      end else begin
        pat_cells[pat_count] = w.cells;
        pat_class[pat_count] = w.load_class;
        pat_sub[pat_count]   = w.load_subclass;
        pat_count++;
      end
      return res;
    end
    win = w.cells;
    win[CELL_W*CENTRE +: CELL_W] = {1'b0, w.stone_color};
    // all variants in search order: swap outermost, column flip innermost
    for (int x = 0; x < NXFORM; x++) begin
      xf = x[4:0];
      views[x] = orient(win, xf[4], int'(xf[3:2]), xf[1], xf[0]);
    end
    for (int k = 0; k < pat_count; k++) begin
      for (int x = 0; x < NXFORM; x++) begin
        ok = 1'b1;
        for (int i = 0; i < NCELL; i++) begin
          wc = views[x][CELL_W*i +: CELL_W];
          pc = pat_cells[k][CELL_W*i +: CELL_W];
          if (!((wc == pc) || wc == C_ANY || pc == C_ANY ||
                (pc == C_NOTWHITE && wc != C_WHITE) ||
                (pc == C_NOTBLACK && wc != C_BLACK) ||
                (wc == C_NOTWHITE && pc != C_WHITE) ||
                (wc == C_NOTBLACK && pc != C_BLACK)))
            ok = 1'b0;
        end
        if (ok) begin
          xf                 = x[4:0];
          res.matched        = 1'b1;
          res.found_class    = pat_class[k];
          res.found_subclass = pat_sub[k];
          res.entry_index    = k[5:0];
          res.colors_swapped = xf[4];
          res.quarter_turns  = xf[3:2];
          res.rows_flipped   = xf[1];
          res.cols_flipped   = xf[0];
          return res;
        end
      end
    end
    return res;
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= PRINT_CAP)
      $display("%0t ns: mismatch: %s", $realtime, msg);
  endtask

  // Offer one word and hold it until taken; returns at the next falling edge
  task automatic send_word(in_word_t w, logic typed, out_word_t want);
    out_word_t predicted;
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (!in_ready);
    predicted = apply_word(w);
    pending_results.push_back(typed ? want : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  // Check each delivered word against the oldest expected result
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report($sformatf("result word %h with nothing expected", out_data));
      end else begin
        want = pending_results.pop_front();
        if (out_data.matched !== want.matched)
          report($sformatf("matched %0d, want %0d", out_data.matched, want.matched));
        if (out_data.found_class !== want.found_class)
          report($sformatf("found_class %0d, want %0d", out_data.found_class,
                           want.found_class));
        if (out_data.found_subclass !== want.found_subclass)
          report($sformatf("found_subclass %0d, want %0d", out_data.found_subclass,
                           want.found_subclass));
        if (out_data.entry_index !== want.entry_index)
          report($sformatf("entry_index %0d, want %0d", out_data.entry_index,
                           want.entry_index));
        if (out_data.colors_swapped !== want.colors_swapped)
          report($sformatf("colors_swapped %0d, want %0d", out_data.colors_swapped,
                           want.colors_swapped));
        if (out_data.quarter_turns !== want.quarter_turns)
          report($sformatf("quarter_turns %0d, want %0d", out_data.quarter_turns,
                           want.quarter_turns));
        if (out_data.rows_flipped !== want.rows_flipped)
          report($sformatf("rows_flipped %0d, want %0d", out_data.rows_flipped,
                           want.rows_flipped));
        if (out_data.cols_flipped !== want.cols_flipped)
          report($sformatf("cols_flipped %0d, want %0d", out_data.cols_flipped,
                           want.cols_flipped));
        if (out_data.load_refused !== want.load_refused)
          report($sformatf("load_refused %0d, want %0d", out_data.load_refused,
                           want.load_refused));
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: stall on changing patterns, with one long hold-off
  initial begin
    rx_mode_t mode;
    int       left;
    out_ready = 1'b0;
    mode      = RX_OPEN;
    left      = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!hold_done && words_sent >= HOLD_AFTER) begin
        // hold off long enough for the block to back up its input
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        RX_OPEN:  out_ready = 1'b1;
        RX_COIN:  out_ready = 1'($urandom_range(0, 1));
        RX_THIRD: out_ready = (left % 3 == 0);
        default:  out_ready = ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Sender: reset, directed words, then bursts of random words
  initial begin
    stim_row_t          directed_rows [$];
    in_word_t           w;
    out_word_t          hit_one;
    logic [CELLS_W-1:0] cells;
    logic [CELL_W-1:0]  code;
    int                 burst;
    int                 gap;
    int                 pick;
    int                 roll;
    int                 k;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;

    // all-empty window with an empty centre hits the all-empty entry as it stands
    hit_one = {1'b1, 8'h00, 8'h00, 6'd1, 1'b0, 2'd0, 1'b0, 1'b0, 1'b0};

    directed_rows = {
      // empty store: nothing can hit
      row(CMD_MATCH, grid(0,0,0, 0,0,0, 0,0,0), 2'd1, 8'h00, 8'h00, 1'b1, NO_HIT),
      row(CMD_LOAD,  grid(7,7,7, 7,7,7, 7,7,7), 2'd3, 8'hFF, 8'hFF, 1'b1, NO_HIT),
      row(CMD_LOAD,  grid(0,0,0, 0,0,0, 0,0,0), 2'd0, 8'h00, 8'h00, 1'b1, NO_HIT),
      // odd stone colours land in the centre as they are
      row(CMD_MATCH, grid(0,0,0, 0,0,0, 0,0,0), 2'd0, 8'h00, 8'h00, 1'b1, hit_one),
      row(CMD_MATCH, grid(0,0,0, 0,0,0, 0,0,0), 2'd3, 8'h00, 8'h00, 1'b1, NO_HIT),
      // undefined code in every window cell but the centre
      row(CMD_MATCH, grid(7,7,7, 7,7,7, 7,7,7), 2'd2, 8'hFF, 8'hFF, 1'b1, NO_HIT),
      // asymmetric entry with wildcards and the undefined code
      row(CMD_LOAD,  grid(7,4,5, 0,6,2, 1,3,0), 2'd1, 8'h81, 8'h18, 1'b1, NO_HIT),
      row(CMD_MATCH, grid(7,1,2, 0,0,2, 1,3,0), 2'd1, 8'h00, 8'h00, 1'b0, NO_HIT),
      row(CMD_MATCH, grid(2,1,7, 2,0,0, 0,3,1), 2'd2, 8'h00, 8'h00, 1'b0, NO_HIT),
      row(CMD_MATCH, grid(7,2,1, 0,0,1, 2,3,0), 2'd2, 8'h00, 8'h00, 1'b0, NO_HIT),
      row(CMD_MATCH, grid(1,0,7, 3,0,1, 0,2,2), 2'd1, 8'h00, 8'h00, 1'b0, NO_HIT),
      row(CMD_MATCH, grid(1,3,0, 0,0,2, 7,1,2), 2'd1, 8'h00, 8'h00, 1'b0, NO_HIT),
      // wildcards on the window side
      row(CMD_MATCH, grid(6,5,4, 6,0,6, 4,6,5), 2'd2, 8'h00, 8'h00, 1'b0, NO_HIT),
      row(CMD_LOAD,  grid(1,2,1, 5,6,4, 3,3,3), 2'd2, 8'hFF, 8'h00, 1'b1, NO_HIT),
      row(CMD_LOAD,  grid(2,2,0, 0,6,0, 0,0,1), 2'd1, 8'h00, 8'hFF, 1'b1, NO_HIT),
      // swapped and turned, then turned only
      row(CMD_MATCH, grid(3,4,2, 3,0,1, 3,5,2), 2'd1, 8'h00, 8'h00, 1'b0, NO_HIT),
      row(CMD_MATCH, grid(0,0,2, 0,0,2, 1,0,0), 2'd1, 8'h00, 8'h00, 1'b0, NO_HIT),
      row(CMD_MATCH, grid(1,1,1, 1,1,1, 1,1,1), 2'd1, 8'h00, 8'h00, 1'b0, NO_HIT),
      row(CMD_MATCH, grid(7,7,7, 7,7,7, 7,7,7), 2'd1, 8'hFF, 8'hFF, 1'b0, NO_HIT),
      row(CMD_MATCH, grid(2,2,2, 2,3,2, 2,2,2), 2'd3, 8'hFF, 8'h00, 1'b0, NO_HIT)
    };

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[n])
      send_word(directed_rows[n].word, directed_rows[n].typed, directed_rows[n].want);

    // pause until every expected result has come back
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);

    burst = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (burst == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) gap = $urandom_range(0, 3);
        else if (roll < 95) gap = $urandom_range(4, 30);
        else gap = $urandom_range(60, 150);
        if (gap > 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
      end
      burst--;

      if (n == RANDOM_WORDS / 2) begin
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end

      w.command       = CMD_MATCH;
      w.cells         = CELLS_W'($urandom);
      w.stone_color   = 2'($urandom_range(0, 3));
      w.load_class    = 8'($urandom);
      w.load_subclass = 8'($urandom);
      pick = $urandom_range(0, 99);

      if (pick < 25) begin
        // new entry: mostly plain colours, some wildcards, rarely the undefined code
        w.command = CMD_LOAD;
        for (int i = 0; i < NCELL; i++) begin
          roll = $urandom_range(0, 99);
          if (roll < 72) code = 3'($urandom_range(0, 3));
          else if (roll < 95) code = 3'($urandom_range(4, 6));
          else code = 3'd7;
          w.cells[CELL_W*i +: CELL_W] = code;
        end
      end else if (pick < 85 && pat_count > 0) begin
        // window drawn from a stored entry, wildcards filled in, then moved about
        k     = $urandom_range(0, pat_count - 1);
        cells = pat_cells[k];
        for (int i = 0; i < NCELL; i++) begin
          code = cells[CELL_W*i +: CELL_W];
          if (code == C_NOTWHITE && $urandom_range(0, 3) != 0) begin
            code = 3'($urandom_range(0, 7));
            if (code == C_WHITE) code = C_BLACK;
          end else if (code == C_NOTBLACK && $urandom_range(0, 3) != 0) begin
            code = 3'($urandom_range(0, 7));
            if (code == C_BLACK) code = C_WHITE;
          end else if (code == C_ANY && $urandom_range(0, 3) != 0) begin
            code = 3'($urandom_range(0, 7));
          end
          cells[CELL_W*i +: CELL_W] = code;
        end
        if ($urandom_range(0, 3) == 0)
          cells[CELL_W*$urandom_range(0, NCELL-1) +: CELL_W] = 3'($urandom_range(0, 7));
        cells = orient(cells, 1'($urandom_range(0, 1)), int'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        code  = cells[CELL_W*CENTRE +: CELL_W];
        if (code < 3'd4 && $urandom_range(0, 7) != 0)
          w.stone_color = code[1:0];
        w.cells = cells;
      end

      send_word(w, 1'b0, NO_HIT);
    end

    // drain, then watch a while for stray results
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
